@@ design/fed_pkg.sv @@
//------------------------------------------------------------------------------
// fed_pkg
// Shared types, widths and register codes for the feedback echo delay core.
//------------------------------------------------------------------------------
`default_nettype none

package fed_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int GAIN_W           = 16;
  localparam int DELAY_W          = 13;
  localparam int CFG_IDX_W        = 8;
  localparam int CFG_DATA_W       = 16;
  localparam int Q_FRAC           = 15;
  localparam int PROD_W           = SAMPLE_W + GAIN_W;
  localparam int SCALED_W         = PROD_W - Q_FRAC;
  localparam int SUM_W            = SCALED_W + 1;
  localparam int BUFFER_DEPTH_DEF = 4096;

  typedef logic signed [SAMPLE_W-1:0]   sample_t;
  typedef logic signed [GAIN_W-1:0]     gain_t;
  typedef logic        [DELAY_W-1:0]    delay_t;
  typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic        [CFG_DATA_W-1:0] cfg_data_t;

  localparam gain_t   GAIN_RST   = 16'sd16384;
  localparam delay_t  DELAY_RST  = 13'd4096;
  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FEEDBACK_GAIN = 8'd0,
    REG_DELAY_SAMPLES = 8'd1
  } cfg_reg_t;

  typedef struct packed {
    logic bypass;
    logic filled;
  } fed_ctl_t;

endpackage

`default_nettype wire

@@ design/fed_in_if.sv @@
//------------------------------------------------------------------------------
// fed_in_if
// Input sample channel: valid/ready handshake with one sample per item.
//------------------------------------------------------------------------------
`default_nettype none

interface fed_in_if;
  import fed_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

@@ design/fed_out_if.sv @@
//------------------------------------------------------------------------------
// fed_out_if
// Result sample channel: valid/ready handshake with one sample per item.
//------------------------------------------------------------------------------
`default_nettype none

interface fed_out_if;
  import fed_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

@@ design/fed_cfg_if.sv @@
//------------------------------------------------------------------------------
// fed_cfg_if
// Register write channel: valid/ready handshake with index and write data.
//------------------------------------------------------------------------------
`default_nettype none

interface fed_cfg_if;
  import fed_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/fed_cfg_regs.sv @@
//------------------------------------------------------------------------------
// fed_cfg_regs
// Feedback gain and delay registers, written through the register channel.
//------------------------------------------------------------------------------
`default_nettype none

module fed_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  fed_cfg_if.sink         cfg,
  output fed_pkg::gain_t  gain,
  output fed_pkg::delay_t delay
);
  import fed_pkg::*;

  gain_t  gain_r;
  delay_t delay_r;

  assign cfg.ready = 1'b1;
  assign gain      = gain_r;
  assign delay     = delay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_RST;
      delay_r <= DELAY_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_FEEDBACK_GAIN: begin
          gain_r <= gain_t'(cfg.data);
        end
        REG_DELAY_SAMPLES: begin
          delay_r <= cfg.data[DELAY_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/fed_ptr.sv @@
//------------------------------------------------------------------------------
// fed_ptr
// Write pointer with wrap, fill tracking and tap address generation.
//------------------------------------------------------------------------------
`default_nettype none

module fed_ptr #(
  parameter int BUFFER_DEPTH = fed_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            advance,
  input  fed_pkg::delay_t                 delay,
  output logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
  output logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
  output logic                            filled
);
  import fed_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = (AW + 1 > DELAY_W) ? AW + 1 : DELAY_W;

  logic [AW-1:0] wp_r;
  logic [AW-1:0] wp_nxt;
  logic          wrap_r;
  logic          wrap_nxt;
  logic          at_end;
  logic [CW-1:0] d_ext;
  logic [CW-1:0] d_eff;
  logic [CW-1:0] wp_ext;
  logic [CW-1:0] rd_ext;

  always_comb begin
    d_ext  = CW'(delay);
    wp_ext = CW'(wp_r);
    if (d_ext == '0 || d_ext > CW'(BUFFER_DEPTH)) begin
      d_eff = CW'(BUFFER_DEPTH);
    end else begin
      d_eff = d_ext;
    end
    if (wp_ext >= d_eff) begin
      rd_ext = wp_ext - d_eff;
    end else begin
      rd_ext = wp_ext + CW'(BUFFER_DEPTH) - d_eff;
    end
    at_end   = (wp_r == AW'(BUFFER_DEPTH - 1));
    wp_nxt   = at_end ? '0 : wp_r + AW'(1);
    wrap_nxt = wrap_r | at_end;
  end

  assign wr_addr = wp_r;
  assign rd_addr = rd_ext[AW-1:0];
  assign filled  = wrap_r || (rd_ext < wp_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      wrap_r <= 1'b0;
    end else if (advance) begin
      wp_r   <= wp_nxt;
      wrap_r <= wrap_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/fed_mem.sv @@
//------------------------------------------------------------------------------
// fed_mem
// Delay line storage: one write port, one registered read port.
//------------------------------------------------------------------------------
`default_nettype none

module fed_mem #(
  parameter int BUFFER_DEPTH = fed_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rd_en,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
  output fed_pkg::sample_t                rd_data,
  input  logic                            wr_en,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
  input  fed_pkg::sample_t                wr_data
);
  import fed_pkg::*;

  sample_t mem [BUFFER_DEPTH];
  sample_t rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/fed_dp.sv @@
//------------------------------------------------------------------------------
// fed_dp
// Tap stage: forwarding, Q1.15 multiply, saturating add, write-back and
// output register.
//------------------------------------------------------------------------------
`default_nettype none

module fed_dp #(
  parameter int BUFFER_DEPTH = fed_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fed_in_if.sink                          in_ch,
  fed_out_if.source                       out_ch,
  input  fed_pkg::gain_t                  gain,
  input  fed_pkg::fed_ctl_t               s0_ctl,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] s0_rd_addr,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] s0_wr_addr,
  input  fed_pkg::sample_t                mem_rdata,
  output logic                            accept,
  output logic                            wr_en,
  output logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
  output fed_pkg::sample_t                wr_data
);
  import fed_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic                       s1_valid_r;
  sample_t                    s1_sample_r;
  fed_ctl_t                   s1_ctl_r;
  logic [AW-1:0]              s1_rd_addr_r;
  logic [AW-1:0]              s1_wr_addr_r;
  logic                       lw_valid_r;
  logic [AW-1:0]              lw_addr_r;
  sample_t                    lw_data_r;
  logic                       out_valid_r;
  sample_t                    out_sample_r;
  logic                       s1_adv;
  sample_t                    tap;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SCALED_W-1:0] scaled;
  logic signed [SUM_W-1:0]    sum;
  sample_t                    sat;
  sample_t                    result;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;

  always_comb begin
    if (lw_valid_r && lw_addr_r == s1_rd_addr_r) begin
      tap = lw_data_r;
    end else if (s1_ctl_r.filled) begin
      tap = mem_rdata;
    end else begin
      tap = '0;
    end
    prod   = tap * gain;
    scaled = $signed(prod[PROD_W-1:Q_FRAC]);
    sum    = {{(SUM_W - SAMPLE_W){s1_sample_r[SAMPLE_W-1]}}, s1_sample_r}
           + {scaled[SCALED_W-1], scaled};
    if (sum[SUM_W-1:SAMPLE_W-1] == '0 || sum[SUM_W-1:SAMPLE_W-1] == '1) begin
      sat = sum[SAMPLE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = SAMPLE_MIN;
    end else begin
      sat = SAMPLE_MAX;
    end
    result = s1_ctl_r.bypass ? s1_sample_r : sat;
  end

  assign wr_en   = s1_adv && !s1_ctl_r.bypass;
  assign wr_addr = s1_wr_addr_r;
  assign wr_data = sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      lw_valid_r  <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        lw_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r  <= in_ch.sample_in;
      s1_ctl_r     <= s0_ctl;
      s1_rd_addr_r <= s0_rd_addr;
      s1_wr_addr_r <= s0_wr_addr;
    end
    if (s1_adv) begin
      out_sample_r <= result;
    end
    if (wr_en) begin
      lw_addr_r <= s1_wr_addr_r;
      lw_data_r <= sat;
    end
  end

endmodule

`default_nettype wire

@@ design/feedback_echo_delay_core.sv @@
//------------------------------------------------------------------------------
// feedback_echo_delay_core
// Feedback echo (recursive comb filter) on signed Q1.15 samples.
//
//   channel  dir  payload               handshake
//   in_ch    in   sample_in   (16 b)    valid/ready
//   out_ch   out  sample_out  (16 b)    valid/ready
//   cfg_ch   in   index (8 b), data     valid/ready, ready always high
//
// One item per cycle sustained while out_ch is ready. The delay memory
// read is registered on accept; the tap stage then multiplies, adds,
// writes back and loads the output register; the last write is forwarded
// for short delays. Unwritten entries read as zero through fill tracking,
// so no clearing pass is run.
// A stalled output holds the tap stage, which then blocks further input.
//------------------------------------------------------------------------------
`default_nettype none

module feedback_echo_delay_core #(
  parameter int BUFFER_DEPTH = fed_pkg::BUFFER_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fed_in_if.sink    in_ch,
  fed_out_if.source out_ch,
  fed_cfg_if.sink   cfg_ch
);
  import fed_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  gain_t         gain;
  delay_t        delay;
  fed_ctl_t      s0_ctl;
  logic          accept;
  logic [AW-1:0] s0_rd_addr;
  logic [AW-1:0] s0_wr_addr;
  logic          filled;
  sample_t       mem_rdata;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  sample_t       wr_data;

  assign s0_ctl.bypass = (gain == '0);
  assign s0_ctl.filled = filled;

  fed_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .gain  (gain),
    .delay (delay)
  );

  fed_ptr #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_ptr (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept && !s0_ctl.bypass),
    .delay   (delay),
    .wr_addr (s0_wr_addr),
    .rd_addr (s0_rd_addr),
    .filled  (filled)
  );

  fed_mem #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (s0_rd_addr),
    .rd_data (mem_rdata),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  fed_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .gain       (gain),
    .s0_ctl     (s0_ctl),
    .s0_rd_addr (s0_rd_addr),
    .s0_wr_addr (s0_wr_addr),
    .mem_rdata  (mem_rdata),
    .accept     (accept),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

endmodule

`default_nettype wire

@@ design/fed_checker.sv @@
//------------------------------------------------------------------------------
// fed_checker
// Port-level checks for the feedback echo delay core, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module fed_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input fed_pkg::sample_t out_sample,
  input logic             cfg_valid,
  input logic             cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output is empty");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted item did not reach the output");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("register write refused");

endmodule

bind feedback_echo_delay_core fed_checker u_fed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample_out),
  .cfg_valid  (cfg_ch.valid),
  .cfg_ready  (cfg_ch.ready)
);

`default_nettype wire
